// ===== design/nearest_flagged_point_search_defines.svh =====
`ifndef NEAREST_FLAGGED_POINT_SEARCH_DEFINES_SVH
`define NEAREST_FLAGGED_POINT_SEARCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nfps_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_SCAN,
        STEP_DRAIN,
        STEP_EMIT
    } t_step;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_QUERY,
        COND_NOT_LAST,
        COND_BUSY,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        logic in_ready;
        logic ld_query;
        logic issue;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic no_query;
        logic not_last;
        logic busy;
        logic out_full;
    } t_flags;

    typedef struct packed {
        t_ctl  ctl;
        t_cond cond;
        t_step target;
    } t_uword;

    // control store: branch to target when cond holds, else fall through
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '0;
        case (step)
            STEP_IDLE: begin
                w.ctl.in_ready = 1'b1;
                w.ctl.ld_query = 1'b1;
                w.cond         = COND_NO_QUERY;
                w.target       = STEP_IDLE;
            end
            STEP_SCAN: begin
                w.ctl.issue = 1'b1;
                w.cond      = COND_NOT_LAST;
                w.target    = STEP_SCAN;
            end
            STEP_DRAIN: begin
                w.cond   = COND_BUSY;
                w.target = STEP_DRAIN;
            end
            STEP_EMIT: begin
                w.ctl.load_out = 1'b1;
                w.cond         = COND_OUT_FULL;
                w.target       = STEP_EMIT;
            end
            default: begin
                w.cond   = COND_NEVER;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/nearest_flagged_point_search.sv =====
// nearest flagged point search
// input stream: tuser selects the item kind (0 = vertex write, 1 = query);
// tdata carries vertex_index, coord_x, coord_y, is_client from the lowest bit.
// a write stores one vertex and its client mark and gives no result; the block
// stays idle and is ready again on the next cycle.
// a query scans every table entry once, one entry per cycle through a single
// read port of the coordinate ram, then a four-stage distance pipeline drains
// and the winner is loaded into the output register; the block then returns
// to idle and takes the next item.
// output stream: tdata holds nearest_index, tuser holds found.
// the result sits in an output register, so a stalled receiver does not stop
// the next writes or the next scan; only a second result waits for the first.
// reset clears all client marks, the sequencer and the output valid; the
// coordinate ram is not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_flagged_point_search_defines.svh"

module nearest_flagged_point_search
    import nfps_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // vertex_index, coord_x, coord_y, is_client
    input  wire logic [((2*COORD_BITS+9+7)/8)*8-1:0] i_s_axis_tdata,
    // operation
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // nearest_index
    output logic [7:0]                 o_m_axis_tdata,
    // found
    output logic                       o_m_axis_tuser
);

    localparam int NENT = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int AW   = $clog2(NENT);
    localparam int DXW  = COORD_BITS + 1;
    localparam int SW   = 2 * DXW;

    t_ctl   w_ctl;
    t_flags w_flags;

    logic                         w_accept;
    logic                         w_query_go;
    logic                         w_we;
    logic [7:0]                   w_idx;
    logic signed [COORD_BITS-1:0] w_x;
    logic signed [COORD_BITS-1:0] w_y;
    logic                         w_mark;
    logic [2*COORD_BITS-1:0]      w_rdata;
    logic signed [COORD_BITS-1:0] w_rx;
    logic signed [COORD_BITS-1:0] w_ry;
    logic                         w_out_full;
    logic                         w_load;
    logic                         n_hit;

    logic [NENT-1:0]              r_marks;
    logic [AW-1:0]                r_addr;
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic                         r_m1, r_m2, r_m3, r_m4;
    logic [AW-1:0]                r_i1, r_i2, r_i3, r_i4;
    logic signed [DXW-1:0]        r_dx, r_dy;
    logic [SW-1:0]                r_sqx, r_sqy;
    logic [SW-1:0]                r_sum;

    logic                         r_have;
    logic [SW-1:0]                r_best;
    logic [AW-1:0]                r_best_idx;

    logic                         r_out_valid;
    logic [7:0]                   r_out_idx;
    logic                         r_out_found;

    nfps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    assign o_s_axis_tready = w_ctl.in_ready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_query_go      = w_accept && w_ctl.ld_query && (i_s_axis_tuser == OP_QUERY);

    assign w_idx  = i_s_axis_tdata[7:0];
    assign w_x    = i_s_axis_tdata[8 +: COORD_BITS];
    assign w_y    = i_s_axis_tdata[8+COORD_BITS +: COORD_BITS];
    assign w_mark = i_s_axis_tdata[8+2*COORD_BITS];

    // writes past the table are dropped
    assign w_we = w_accept && (i_s_axis_tuser == OP_WRITE)
                  && (32'(w_idx) < 32'(MAX_VERTICES));

    nfps_ram #(
        .WIDTH (2*COORD_BITS),
        .DEPTH (NENT)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx[AW-1:0]),
        .i_wdata ({w_y, w_x}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_rx = w_rdata[COORD_BITS-1:0];
    assign w_ry = w_rdata[2*COORD_BITS-1:COORD_BITS];

    assign w_out_full = r_out_valid && !i_m_axis_tready;
    assign w_load     = w_ctl.load_out && !w_out_full;

    always_comb begin
        w_flags.no_query = !w_query_go;
        w_flags.not_last = (r_addr != AW'(NENT - 1));
        w_flags.busy     = r_v1 || r_v2 || r_v3 || r_v4;
        w_flags.out_full = w_out_full;
    end

    // strict less-than keeps the lowest index on a tie
    assign n_hit = r_v4 && r_m4 && (!r_have || (r_sum < r_best));

    // client marks and scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_addr  <= '0;
        end else begin
            if (w_we) begin
                r_marks[w_idx[AW-1:0]] <= w_mark;
            end
            if (w_query_go) begin
                r_addr <= '0;
            end else if (w_ctl.issue) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query_go) begin
            r_qx <= w_x;
            r_qy <= w_y;
        end
    end

    // distance pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // distance pipeline payload: read, difference, square, sum
    always_ff @(posedge i_clk) begin
        r_m1  <= r_marks[r_addr];
        r_i1  <= r_addr;
        r_m2  <= r_m1;
        r_i2  <= r_i1;
        r_dx  <= DXW'(w_rx) - DXW'(r_qx);
        r_dy  <= DXW'(w_ry) - DXW'(r_qy);
        r_m3  <= r_m2;
        r_i3  <= r_i2;
        r_sqx <= SW'(r_dx) * SW'(r_dx);
        r_sqy <= SW'(r_dy) * SW'(r_dy);
        r_m4  <= r_m3;
        r_i4  <= r_i3;
        r_sum <= r_sqx + r_sqy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_query_go) begin
            r_have <= 1'b0;
        end else if (n_hit) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query_go) begin
            r_best_idx <= '0;
        end else if (n_hit) begin
            r_best     <= r_sum;
            r_best_idx <= r_i4;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx   <= r_have ? 8'(r_best_idx) : 8'd0;
            r_out_found <= r_have;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_idx;
    assign o_m_axis_tuser  = r_out_found;

    `NFPS_ASSERT_SAME(a_ready_only_when_drained, i_clk, i_rst_n,
        o_s_axis_tready, !(r_v1 || r_v2 || r_v3 || r_v4), "input taken during a scan")

    `NFPS_ASSERT_NEXT(a_query_starts_clean, i_clk, i_rst_n,
        w_query_go, (r_addr == '0) && !r_have, "scan did not restart at entry zero")

    `NFPS_ASSERT_SAME(a_no_client_zero_index, i_clk, i_rst_n,
        r_out_valid && !r_out_found, r_out_idx == 8'd0, "index set without a client")

    `NFPS_ASSERT_NEXT(a_result_kept_on_stall, i_clk, i_rst_n,
        r_out_valid && !i_m_axis_tready, r_out_valid, "pending result dropped")

endmodule

`default_nettype wire

// ===== design/nfps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/nfps_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfps_seq
    import nfps_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_ctl        o_ctl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    assign w_word = ucode(r_step);

    always_comb begin
        case (w_word.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_NO_QUERY: w_take = i_flags.no_query;
            COND_NOT_LAST: w_take = i_flags.not_last;
            COND_BUSY:     w_take = i_flags.busy;
            COND_OUT_FULL: w_take = i_flags.out_full;
            default:       w_take = 1'b0;
        endcase
    end

    // next step: branch target or fall through (last step wraps to idle)
    always_comb begin
        if (w_take) begin
            n_step = w_word.target;
        end else begin
            n_step = t_step'(r_step + 2'd1);
        end
    end

    always_comb begin
        o_ctl = w_word.ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire
